// File: rtl/ird_pkg.sv
// Shared types and constants for the IR remote pulse decoder.
// Holds field widths, register reset values, register indexes and channel payloads.
// No dependencies.
`timescale 1ns / 1ps

package ird_pkg;

    localparam int EDGE_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int FRAME_W    = 14;
    localparam int CMD_W      = 7;
    localparam int ADDR_W     = 5;
    localparam int SONY_FLD_W = CMD_W + ADDR_W;
    localparam int TOL_W      = 10;
    localparam int TIME_W     = 12;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic         PROTOCOL_RESET = 1'b0;
    localparam logic [TOL_W-1:0]  TOL_RESET      = 10'd100;
    localparam logic [TIME_W-1:0] RC5_HALF_RESET = 12'd889;
    localparam logic [TIME_W-1:0] SONY_ONE_RESET = 12'd1200;

    localparam logic         MODE_RC5  = 1'b0;
    localparam logic         MODE_SONY = 1'b1;

    localparam logic [EDGE_W-1:0] RC5_START_EDGE  = 8'd2;
    localparam logic [EDGE_W-1:0] SONY_CLEAR_EDGE = 8'd3;

    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROTOCOL_MODE   = 2'd0,
        REG_TOLERANCE_US    = 2'd1,
        REG_RC5_HALF_BIT_US = 2'd2,
        REG_SONY_ONE_US     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [EDGE_W-1:0]     edge_index;
        logic [INTERVAL_W-1:0] interval_us;
    } ird_in_t;

    typedef struct packed {
        logic               frame_done;
        logic [FRAME_W-1:0] frame_value;
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  address;
    } ird_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } ird_cfg_t;

endpackage

// File: rtl/ird_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is a parameter; the decoder uses the structs of ird_pkg.
`timescale 1ns / 1ps

interface ird_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ir_remote_pulse_decoder.sv
// IR remote pulse decoder, RC5 and Sony SIRC. Depends on ird_pkg and ird_stream_if.
// An accepted edge is held in the input register, and its result is loaded into
// the result register once that register is free.
// Throughput: one edge per cycle unless the output stalls; the decode state is updated
// by a single pass of compare-and-shift logic between the input and result registers.
// Reset: rst_n clears decode state to zero and loads the default timing registers.
`timescale 1ns / 1ps

module ir_remote_pulse_decoder #(
    parameter int RC5_FRAME_BITS  = 14,
    parameter int SONY_FRAME_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    ird_stream_if.sink   edges,
    ird_stream_if.source frames,
    ird_stream_if.sink   cfg
);
    import ird_pkg::*;

    // Shift register width: Sony bits enter at the top, RC5 uses bit 0 only.
    localparam int LBS_W = SONY_FRAME_BITS;

    // ---------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ---------------------------------------------------------------------
    logic              mode_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [TIME_W-1:0] half_reg;
    logic [TIME_W-1:0] one_reg;
    ird_cfg_t          cfg_word;

    assign cfg.ready = 1'b1;
    assign cfg_word  = cfg.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PROTOCOL_RESET;
            tol_reg  <= TOL_RESET;
            half_reg <= RC5_HALF_RESET;
            one_reg  <= SONY_ONE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg_word.index))
                REG_PROTOCOL_MODE:   mode_reg <= cfg_word.value[0];
                REG_TOLERANCE_US:    tol_reg  <= cfg_word.value[TOL_W-1:0];
                REG_RC5_HALF_BIT_US: half_reg <= cfg_word.value[TIME_W-1:0];
                REG_SONY_ONE_US:     one_reg  <= cfg_word.value[TIME_W-1:0];
                default:             mode_reg <= mode_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: input register feeds the decode pass, result register
    // holds the output. An empty input register refills while a result waits.
    // ---------------------------------------------------------------------
    logic     in_valid_reg;
    ird_in_t  in_data_reg;
    logic     out_valid_reg;
    ird_out_t out_data_reg;
    ird_out_t out_data_next;
    logic     advance;
    logic     step;

    assign advance      = !out_valid_reg || frames.ready;
    assign step         = in_valid_reg && advance;
    assign edges.ready  = !in_valid_reg || advance;
    assign frames.valid = out_valid_reg;
    assign frames.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (edges.ready)
            begin
                in_valid_reg <= edges.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (edges.valid && edges.ready)
        begin
            in_data_reg <= edges.data;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------------------------------------------------------------
    // Decode state.
    // ---------------------------------------------------------------------
    logic [CNT_W-1:0]      bits_reg,  bits_next;
    logic [LBS_W-1:0]      lbs_reg,   lbs_next;
    logic [1:0]            phase_reg, phase_next;
    logic [FRAME_W-1:0]    fs_reg,    fs_next;
    logic [SONY_FLD_W-1:0] sf_reg,    sf_next;
    logic                  done_next;

    // Open window: strictly between nominal - tol (floored at zero) and nominal + tol.
    function automatic logic in_window(
        input logic [INTERVAL_W-1:0] t,
        input logic [TIME_W:0]       nominal,
        input logic [TOL_W-1:0]      tol
    );
        logic [TIME_W:0]   lo;
        logic [TIME_W+1:0] hi;
        lo = (nominal > {3'b000, tol}) ? nominal - {3'b000, tol} : '0;
        hi = {1'b0, nominal} + {4'b0000, tol};
        return ({3'b000, lo} < t) && (t < {2'b00, hi});
    endfunction

    logic long_hit;
    logic short_hit;
    logic sony_hit;

    assign long_hit  = in_window(in_data_reg.interval_us, {half_reg, 1'b0}, tol_reg);
    assign short_hit = in_window(in_data_reg.interval_us, {1'b0, half_reg}, tol_reg);
    assign sony_hit  = in_window(in_data_reg.interval_us, {1'b0, one_reg}, tol_reg);

    always_comb
    begin
        bits_next  = bits_reg;
        lbs_next   = lbs_reg;
        phase_next = phase_reg;
        fs_next    = fs_reg;
        sf_next    = sf_reg;
        done_next  = 1'b0;

        if (mode_reg == MODE_RC5)
        begin
            if (in_data_reg.edge_index == RC5_START_EDGE)
            begin
                // Start bit: frame holds a single one.
                phase_next = PHASE_FIRST;
                bits_next  = CNT_W'(1);
                lbs_next   = LBS_W'(1);
                fs_next    = FRAME_W'(1);
            end
            else if (in_data_reg.edge_index > RC5_START_EDGE)
            begin
                // Long interval: toggle the bit and append it.
                if (long_hit)
                begin
                    lbs_next   = lbs_reg ^ LBS_W'(1);
                    fs_next    = {fs_reg[FRAME_W-2:0], lbs_next[0]};
                    phase_next = PHASE_FIRST;
                    bits_next  = bits_reg + CNT_W'(1);
                end
                // Short interval: second short in a row appends the same bit.
                if (short_hit)
                begin
                    if (phase_next == PHASE_FIRST)
                    begin
                        phase_next = PHASE_SECOND;
                    end
                    else
                    begin
                        fs_next    = {fs_next[FRAME_W-2:0], lbs_next[0]};
                        phase_next = PHASE_FIRST;
                        bits_next  = bits_next + CNT_W'(1);
                    end
                end
            end
            done_next = (bits_next == CNT_W'(RC5_FRAME_BITS));
        end
        else
        begin
            if (in_data_reg.edge_index == SONY_CLEAR_EDGE)
            begin
                bits_next = '0;
                lbs_next  = '0;
                fs_next   = '0;
            end
            else if (!in_data_reg.edge_index[0])
            begin
                // Even edge: shift in one bit from the top, LSB first.
                bits_next = bits_reg + CNT_W'(1);
                lbs_next  = {sony_hit, lbs_reg[LBS_W-1:1]};
                if (bits_next == CNT_W'(SONY_FRAME_BITS))
                begin
                    fs_next   = FRAME_W'(lbs_next);
                    sf_next   = fs_next[SONY_FLD_W-1:0];
                    done_next = 1'b1;
                end
            end
        end

        out_data_next.frame_done  = done_next;
        out_data_next.frame_value = fs_next;
        out_data_next.command     = (mode_reg == MODE_SONY) ? sf_next[CMD_W-1:0] : '0;
        out_data_next.address     = (mode_reg == MODE_SONY) ?
                                    sf_next[SONY_FLD_W-1:CMD_W] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            lbs_reg   <= '0;
            phase_reg <= '0;
            fs_reg    <= '0;
            sf_reg    <= '0;
        end
        else if (step)
        begin
            bits_reg  <= bits_next;
            lbs_reg   <= lbs_next;
            phase_reg <= phase_next;
            fs_reg    <= fs_next;
            sf_reg    <= sf_next;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // Input side stalls only when both the input and the result register are held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !edges.ready |-> (in_valid_reg && out_valid_reg && !frames.ready))
        else $error("input stalled without a held result");

    // A completed Sony frame latches fields that match the frame register.
    a_sony_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_SONY && done_next)
        |=> (sf_reg == fs_reg[SONY_FLD_W-1:0]))
        else $error("Sony fields differ from latched frame");

    // Sony odd edges other than the clear edge leave the state untouched.
    a_sony_odd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_SONY && in_data_reg.edge_index[0]
         && in_data_reg.edge_index != SONY_CLEAR_EDGE)
        |=> ($stable(bits_reg) && $stable(lbs_reg) && $stable(fs_reg)))
        else $error("Sony odd edge changed decode state");

    // The RC5 start edge restarts the frame with a single one bit.
    a_rc5_start: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_RC5 && in_data_reg.edge_index == RC5_START_EDGE)
        |=> (bits_reg == CNT_W'(1) && fs_reg == FRAME_W'(1) && phase_reg == PHASE_FIRST))
        else $error("RC5 start edge did not restart the frame");

    // A result register update always follows a decode step.
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && out_data_reg == $past(out_data_next)))
        else $error("result register missed a decode step");

endmodule
